[design/dpd_pkg.sv]
`default_nettype none

package dpd_pkg;

  // pipeline depth: normalize 2, distortion 10, depth scaling 3
  localparam int unsigned STAGES = 15;

  typedef logic [STAGES-1:0] stage_en_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_PRINCIPAL_POINT = 3'd0,
    REG_INV_FOCAL_X     = 3'd1,
    REG_INV_FOCAL_Y     = 3'd2,
    REG_RADIAL_K1       = 3'd3,
    REG_RADIAL_K2       = 3'd4,
    REG_RADIAL_K3       = 3'd5,
    REG_TANGENTIAL_P1   = 3'd6,
    REG_TANGENTIAL_P2   = 3'd7
  } cfg_reg_t;

  // values after reset
  localparam logic [31:0] PRINCIPAL_POINT_RST = 32'h0F00_1A80;
  localparam logic [23:0] INV_FOCAL_RST       = 24'd39569;

  // half an lsb for a shift by 24
  localparam logic [64:0] HALF_Q24 = 65'd8388608;

  // saturate a signed value to signed 32 bits
  function automatic logic signed [31:0] ssat32(input logic signed [64:0] v);
    logic signed [31:0] r;
    if (v > 65'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -65'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // saturate an unsigned value to 32 bits
  function automatic logic [31:0] usat32(input logic [64:0] v);
    logic [31:0] r;
    if (v > 65'h0_FFFF_FFFF) begin
      r = 32'hFFFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/depth_pixel_deprojection.sv]
`default_nettype none

// channel  direction  handshake             payload
// in       input      in_valid / in_stall   column, row, depth_mm
// out      output     out_valid / out_stall point_x, point_y, point_z
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// fifteen register stages; one word enters per cycle while the input is not
// stalled, and each result leaves from the last stage register. the multiplier
// chain for r2, r4 and r6 sets the depth. reset clears the valid bits and loads
// the default camera registers. a stall holds the output word; upstream stages
// keep filling empty slots and stall the input only when every stage is full.

module depth_pixel_deprojection
  import dpd_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = 1024,
  parameter int unsigned MAX_ROWS    = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [9:0]         column,
  input  wire logic [9:0]         row,
  input  wire logic [15:0]        depth_mm,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [27:0]      point_x,
  output logic signed [27:0]      point_y,
  output logic [15:0]             point_z,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  logic [31:0]         principal_point;
  logic [23:0]         inv_focal_x;
  logic [23:0]         inv_focal_y;
  logic signed [25:0]  radial_k1;
  logic signed [25:0]  radial_k2;
  logic signed [25:0]  radial_k3;
  logic signed [25:0]  tangential_p1;
  logic signed [25:0]  tangential_p2;

  stage_en_t           load;
  logic signed [31:0]  norm_x, norm_y;
  logic [15:0]         norm_depth;
  logic signed [64:0]  acc_x, acc_y;
  logic [15:0]         acc_depth;

  assign cfg_ready = 1'b1;

  // camera registers
  always_ff @(posedge clk) begin
    if (rst) begin
      principal_point <= PRINCIPAL_POINT_RST;
      inv_focal_x     <= INV_FOCAL_RST;
      inv_focal_y     <= INV_FOCAL_RST;
      radial_k1       <= '0;
      radial_k2       <= '0;
      radial_k3       <= '0;
      tangential_p1   <= '0;
      tangential_p2   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_PRINCIPAL_POINT: principal_point <= cfg_data;
        REG_INV_FOCAL_X:     inv_focal_x     <= cfg_data[23:0];
        REG_INV_FOCAL_Y:     inv_focal_y     <= cfg_data[23:0];
        REG_RADIAL_K1:       radial_k1       <= $signed(cfg_data[25:0]);
        REG_RADIAL_K2:       radial_k2       <= $signed(cfg_data[25:0]);
        REG_RADIAL_K3:       radial_k3       <= $signed(cfg_data[25:0]);
        REG_TANGENTIAL_P1:   tangential_p1   <= $signed(cfg_data[25:0]);
        REG_TANGENTIAL_P2:   tangential_p2   <= $signed(cfg_data[25:0]);
        default: ;
      endcase
    end
  end

  // stage valid bits and load enables
  dpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .load      (load)
  );

  // pixel to normalized coordinates
  dpd_normalize #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_normalize (
    .clk             (clk),
    .en              (load[1:0]),
    .principal_point (principal_point),
    .inv_focal_x     (inv_focal_x),
    .inv_focal_y     (inv_focal_y),
    .column          (column),
    .row             (row),
    .depth_mm        (depth_mm),
    .norm_x          (norm_x),
    .norm_y          (norm_y),
    .depth           (norm_depth)
  );

  // radial and tangential correction
  dpd_distort u_distort (
    .clk           (clk),
    .en            (load[11:2]),
    .radial_k1     (radial_k1),
    .radial_k2     (radial_k2),
    .radial_k3     (radial_k3),
    .tangential_p1 (tangential_p1),
    .tangential_p2 (tangential_p2),
    .norm_x        (norm_x),
    .norm_y        (norm_y),
    .depth_in      (norm_depth),
    .acc_x         (acc_x),
    .acc_y         (acc_y),
    .depth         (acc_depth)
  );

  // depth scaling and output register
  dpd_scale u_scale (
    .clk      (clk),
    .en       (load[14:12]),
    .acc_x    (acc_x),
    .acc_y    (acc_y),
    .depth_in (acc_depth),
    .point_x  (point_x),
    .point_y  (point_y),
    .point_z  (point_z)
  );

endmodule

`default_nettype wire

[design/dpd_ctrl.sv]
`default_nettype none

module dpd_ctrl
  import dpd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  output stage_en_t      load
);

  stage_en_t         valid;
  logic [STAGES:0]   ready;

  // a stage loads when it is empty or its word moves on
  always_comb begin
    ready[STAGES] = !out_stall;
    for (int i = STAGES - 1; i >= 0; i--) begin
      ready[i] = !valid[i] || ready[i+1];
    end
  end

  assign load      = ready[STAGES-1:0];
  assign in_stall  = !ready[0];
  assign out_valid = valid[STAGES-1];

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= (valid & ~load) | ({valid[STAGES-2:0], in_valid} & load);
    end
  end

endmodule

`default_nettype wire

[design/dpd_normalize.sv]
`default_nettype none

module dpd_normalize
  import dpd_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = 1024,
  parameter int unsigned MAX_ROWS    = 1024
) (
  input  wire logic               clk,
  input  wire logic [1:0]         en,
  input  wire logic [31:0]        principal_point,
  input  wire logic [23:0]        inv_focal_x,
  input  wire logic [23:0]        inv_focal_y,
  input  wire logic [9:0]         column,
  input  wire logic [9:0]         row,
  input  wire logic [15:0]        depth_mm,
  output logic signed [31:0]      norm_x,
  output logic signed [31:0]      norm_y,
  output logic [15:0]             depth
);

  localparam logic [12:0] COL_LIM = 13'(MAX_COLUMNS - 1);
  localparam logic [12:0] ROW_LIM = 13'(MAX_ROWS - 1);

  logic [9:0]          col_c;
  logic [9:0]          row_c;
  logic signed [17:0]  dx;
  logic signed [17:0]  dy;
  logic signed [42:0]  prodx;
  logic signed [42:0]  prody;
  logic signed [42:0]  s1_prodx;
  logic signed [42:0]  s1_prody;
  logic [15:0]         s1_depth;
  logic signed [42:0]  sumx;
  logic signed [42:0]  sumy;

  // clip to the image, offset by the principal point, scale by 1/f
  always_comb begin
    col_c = ({3'b000, column} > COL_LIM) ? COL_LIM[9:0] : column;
    row_c = ({3'b000, row} > ROW_LIM) ? ROW_LIM[9:0] : row;
    dx    = $signed({4'b0000, col_c, 4'b0000}) - $signed({2'b00, principal_point[15:0]});
    dy    = $signed({4'b0000, row_c, 4'b0000}) - $signed({2'b00, principal_point[31:16]});
    prodx = dx * $signed({1'b0, inv_focal_x});
    prody = dy * $signed({1'b0, inv_focal_y});
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_prodx <= prodx;
      s1_prody <= prody;
      s1_depth <= depth_mm;
    end
  end

  // round to q.24 and saturate
  always_comb begin
    sumx = s1_prodx + 43'sd8;
    sumy = s1_prody + 43'sd8;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      norm_x <= ssat32(65'($signed(sumx[42:4])));
      norm_y <= ssat32(65'($signed(sumy[42:4])));
      depth  <= s1_depth;
    end
  end

endmodule

`default_nettype wire

[design/dpd_distort.sv]
`default_nettype none

module dpd_distort
  import dpd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic [9:0]         en,
  input  wire logic signed [25:0] radial_k1,
  input  wire logic signed [25:0] radial_k2,
  input  wire logic signed [25:0] radial_k3,
  input  wire logic signed [25:0] tangential_p1,
  input  wire logic signed [25:0] tangential_p2,
  input  wire logic signed [31:0] norm_x,
  input  wire logic signed [31:0] norm_y,
  input  wire logic [15:0]        depth_in,
  output logic signed [64:0]      acc_x,
  output logic signed [64:0]      acc_y,
  output logic [15:0]             depth
);

  localparam logic signed [61:0] F_BIAS = 62'sd281474985099264;

  // stage 3: squares and cross product
  logic [63:0]         s3_sqx, s3_sqy;
  logic signed [63:0]  s3_pxy;
  logic signed [31:0]  s3_x, s3_y;
  logic [15:0]         s3_depth;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s3_sqx   <= norm_x * norm_x;
      s3_sqy   <= norm_y * norm_y;
      s3_pxy   <= norm_x * norm_y;
      s3_x     <= norm_x;
      s3_y     <= norm_y;
      s3_depth <= depth_in;
    end
  end

  // stage 4: r2, x2, y2, xy
  logic [63:0]         sum_x2, sum_y2;
  logic [64:0]         sum_r2;
  logic signed [63:0]  sum_xy;
  logic [38:0]         s4_x2, s4_y2;
  logic [31:0]         s4_r2;
  logic signed [31:0]  s4_xy, s4_x, s4_y;
  logic [15:0]         s4_depth;

  always_comb begin
    sum_x2 = s3_sqx + 64'd8388608;
    sum_y2 = s3_sqy + 64'd8388608;
    sum_r2 = {1'b0, s3_sqx} + {1'b0, s3_sqy} + HALF_Q24;
    sum_xy = s3_pxy + 64'sd8388608;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s4_x2    <= sum_x2[62:24];
      s4_y2    <= sum_y2[62:24];
      s4_r2    <= usat32(65'(sum_r2[64:24]));
      s4_xy    <= ssat32(65'($signed(sum_xy[63:24])));
      s4_x     <= s3_x;
      s4_y     <= s3_y;
      s4_depth <= s3_depth;
    end
  end

  // stage 5: r2 squared, k1 term, tangential sums
  logic [63:0]         s5_r4raw;
  logic signed [58:0]  s5_pk1;
  logic [31:0]         s5_qx, s5_qy, s5_r2;
  logic signed [31:0]  s5_xy, s5_x, s5_y;
  logic [15:0]         s5_depth;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s5_r4raw <= s4_r2 * s4_r2;
      s5_pk1   <= radial_k1 * $signed({1'b0, s4_r2});
      s5_qx    <= usat32(65'(s4_r2) + 65'({s4_x2, 1'b0}));
      s5_qy    <= usat32(65'(s4_r2) + 65'({s4_y2, 1'b0}));
      s5_r2    <= s4_r2;
      s5_xy    <= s4_xy;
      s5_x     <= s4_x;
      s5_y     <= s4_y;
      s5_depth <= s4_depth;
    end
  end

  // stage 6: round r4
  logic [64:0]         sum_r4;
  logic [31:0]         s6_r4, s6_r2, s6_qx, s6_qy;
  logic signed [58:0]  s6_pk1;
  logic signed [31:0]  s6_xy, s6_x, s6_y;
  logic [15:0]         s6_depth;

  assign sum_r4 = {1'b0, s5_r4raw} + HALF_Q24;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s6_r4    <= usat32(65'(sum_r4[64:24]));
      s6_r2    <= s5_r2;
      s6_qx    <= s5_qx;
      s6_qy    <= s5_qy;
      s6_pk1   <= s5_pk1;
      s6_xy    <= s5_xy;
      s6_x     <= s5_x;
      s6_y     <= s5_y;
      s6_depth <= s5_depth;
    end
  end

  // stage 7: r4 times r2, k2 term
  logic [63:0]         s7_r6raw;
  logic signed [58:0]  s7_pk1, s7_pk2;
  logic [31:0]         s7_qx, s7_qy;
  logic signed [31:0]  s7_xy, s7_x, s7_y;
  logic [15:0]         s7_depth;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s7_r6raw <= s6_r4 * s6_r2;
      s7_pk2   <= radial_k2 * $signed({1'b0, s6_r4});
      s7_pk1   <= s6_pk1;
      s7_qx    <= s6_qx;
      s7_qy    <= s6_qy;
      s7_xy    <= s6_xy;
      s7_x     <= s6_x;
      s7_y     <= s6_y;
      s7_depth <= s6_depth;
    end
  end

  // stage 8: round r6, add first two radial terms
  logic [64:0]         sum_r6;
  logic [31:0]         s8_r6, s8_qx, s8_qy;
  logic signed [59:0]  s8_s12;
  logic signed [31:0]  s8_xy, s8_x, s8_y;
  logic [15:0]         s8_depth;

  assign sum_r6 = {1'b0, s7_r6raw} + HALF_Q24;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s8_r6    <= usat32(65'(sum_r6[64:24]));
      s8_s12   <= 60'(s7_pk1) + 60'(s7_pk2);
      s8_qx    <= s7_qx;
      s8_qy    <= s7_qy;
      s8_xy    <= s7_xy;
      s8_x     <= s7_x;
      s8_y     <= s7_y;
      s8_depth <= s7_depth;
    end
  end

  // stage 9: k3 term
  logic signed [58:0]  s9_pk3;
  logic signed [59:0]  s9_s12;
  logic [31:0]         s9_qx, s9_qy;
  logic signed [31:0]  s9_xy, s9_x, s9_y;
  logic [15:0]         s9_depth;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s9_pk3   <= radial_k3 * $signed({1'b0, s8_r6});
      s9_s12   <= s8_s12;
      s9_qx    <= s8_qx;
      s9_qy    <= s8_qy;
      s9_xy    <= s8_xy;
      s9_x     <= s8_x;
      s9_y     <= s8_y;
      s9_depth <= s8_depth;
    end
  end

  // stage 10: radial factor, one plus rounded sum, saturated
  logic signed [61:0]  fsum;
  logic signed [31:0]  s10_f, s10_xy, s10_x, s10_y;
  logic [31:0]         s10_qx, s10_qy;
  logic [15:0]         s10_depth;

  assign fsum = 62'(s9_s12) + 62'(s9_pk3) + F_BIAS;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s10_f     <= ssat32(65'($signed(fsum[61:24])));
      s10_qx    <= s9_qx;
      s10_qy    <= s9_qy;
      s10_xy    <= s9_xy;
      s10_x     <= s9_x;
      s10_y     <= s9_y;
      s10_depth <= s9_depth;
    end
  end

  // stage 11: correction products
  logic signed [63:0]  s11_xf, s11_yf;
  logic signed [57:0]  s11_t1x, s11_t1y;
  logic signed [58:0]  s11_t2x, s11_t2y;
  logic [15:0]         s11_depth;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s11_xf    <= s10_x * s10_f;
      s11_yf    <= s10_y * s10_f;
      s11_t1x   <= tangential_p1 * s10_xy;
      s11_t1y   <= tangential_p2 * s10_xy;
      s11_t2x   <= tangential_p2 * $signed({1'b0, s10_qx});
      s11_t2y   <= tangential_p1 * $signed({1'b0, s10_qy});
      s11_depth <= s10_depth;
    end
  end

  // stage 12: corrected coordinates in q.48
  always_ff @(posedge clk) begin
    if (en[9]) begin
      acc_x <= 65'(s11_xf) + (65'(s11_t1x) <<< 1) + 65'(s11_t2x);
      acc_y <= 65'(s11_yf) + (65'(s11_t1y) <<< 1) + 65'(s11_t2y);
      depth <= s11_depth;
    end
  end

endmodule

`default_nettype wire

[design/dpd_scale.sv]
`default_nettype none

module dpd_scale
  import dpd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic [2:0]         en,
  input  wire logic signed [64:0] acc_x,
  input  wire logic signed [64:0] acc_y,
  input  wire logic [15:0]        depth_in,
  output logic signed [27:0]      point_x,
  output logic signed [27:0]      point_y,
  output logic [15:0]             point_z
);

  // saturate to signed q19.8
  function automatic logic signed [27:0] sat28(input logic signed [41:0] v);
    logic signed [27:0] r;
    if (v > 42'sd134217727) begin
      r = 28'sh7FF_FFFF;
    end else if (v < -42'sd134217728) begin
      r = 28'sh800_0000;
    end else begin
      r = v[27:0];
    end
    return r;
  endfunction

  logic signed [64:0]  sum_nx, sum_ny;
  logic signed [40:0]  s13_nx, s13_ny;
  logic [15:0]         s13_depth;
  logic signed [57:0]  s14_mx, s14_my;
  logic [15:0]         s14_depth;
  logic signed [57:0]  sum_px, sum_py;

  // stage 13: round back to q.24
  always_comb begin
    sum_nx = acc_x + 65'sd8388608;
    sum_ny = acc_y + 65'sd8388608;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s13_nx    <= $signed(sum_nx[64:24]);
      s13_ny    <= $signed(sum_ny[64:24]);
      s13_depth <= depth_in;
    end
  end

  // stage 14: scale by depth
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s14_mx    <= s13_nx * $signed({1'b0, s13_depth});
      s14_my    <= s13_ny * $signed({1'b0, s13_depth});
      s14_depth <= s13_depth;
    end
  end

  // stage 15: round to q.8 and saturate into the output word
  always_comb begin
    sum_px = s14_mx + 58'sd32768;
    sum_py = s14_my + 58'sd32768;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      point_x <= sat28($signed(sum_px[57:16]));
      point_y <= sat28($signed(sum_py[57:16]));
      point_z <= s14_depth;
    end
  end

endmodule

`default_nettype wire

[dv/tb.sv]
`default_nettype none

module tb;
  import dpd_pkg::*;

  localparam int COLUMN_LIMIT = 1024;
  localparam int ROW_LIMIT    = 1024;
  localparam int CYCLE_LIMIT  = 200000;
  localparam longint unsigned HALF_LSB_24 = 64'd8388608;

  typedef struct {
    logic [9:0]  column;
    logic [9:0]  row;
    logic [15:0] depth;
  } pixel_t;

  typedef struct {
    logic signed [27:0] x;
    logic signed [27:0] y;
    logic [15:0]        z;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [9:0]         column   = '0;
  logic [9:0]         row      = '0;
  logic [15:0]        depth_mm = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [27:0] point_x;
  logic signed [27:0] point_y;
  logic [15:0]        point_z;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data  = '0;

  // camera copy used for prediction
  logic [31:0] cam_center = PRINCIPAL_POINT_RST;
  logic [23:0] cam_inv_fx = INV_FOCAL_RST;
  logic [23:0] cam_inv_fy = INV_FOCAL_RST;
  longint      cam_k1 = 0;
  longint      cam_k2 = 0;
  longint      cam_k3 = 0;
  longint      cam_p1 = 0;
  longint      cam_p2 = 0;

  pixel_t pending_pixels[$];
  point_t expected_points[$];
  pixel_t next_px;
  point_t want;

  int  send_gap       = 0;
  int  stall_left     = 0;
  bit  steady_in      = 1'b0;
  bit  steady_out     = 1'b0;
  int  mismatch_count = 0;
  int  cycles         = 0;

  depth_pixel_deprojection uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .column    (column),
    .row       (row),
    .depth_mm  (depth_mm),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // round half up, floor shift
  function automatic longint round_half_up(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned clip_u32(longint unsigned v);
    return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
  endfunction

  // scale a corrected q.48 coordinate by depth into saturated q19.8
  function automatic logic signed [27:0] scale_by_depth(longint acc, longint depth);
    longint n;
    longint v;
    n = round_half_up(acc, 24);
    v = round_half_up(n * depth, 16);
    if (v > (longint'(1) << 27) - 1) v = (longint'(1) << 27) - 1;
    if (v < -(longint'(1) << 27)) v = -(longint'(1) << 27);
    return v[27:0];
  endfunction

  // normalize, apply radial and tangential correction, scale by depth
  function automatic point_t project_pixel(logic [9:0] col_in, logic [9:0] row_in,
                                           logic [15:0] dep);
    longint col, rw, depth, cx, cy, x, y, f, xy, accx, accy;
    longint unsigned ax, ay, x2, y2, r2, r4, r6, qx, qy;
    point_t p;
    col   = col_in;
    rw    = row_in;
    depth = dep;
    if (col > COLUMN_LIMIT - 1) col = COLUMN_LIMIT - 1;
    if (rw > ROW_LIMIT - 1) rw = ROW_LIMIT - 1;
    cx = cam_center[15:0];
    cy = cam_center[31:16];

    x = clip_s32(round_half_up((col * 16 - cx) * longint'(cam_inv_fx), 4));
    y = clip_s32(round_half_up((rw * 16 - cy) * longint'(cam_inv_fy), 4));

    // radius powers, unsigned q8.24
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    x2 = (ax * ax + HALF_LSB_24) >> 24;
    y2 = (ay * ay + HALF_LSB_24) >> 24;
    r2 = clip_u32((ax * ax + ay * ay + HALF_LSB_24) >> 24);
    r4 = clip_u32((r2 * r2 + HALF_LSB_24) >> 24);
    r6 = clip_u32((r4 * r2 + HALF_LSB_24) >> 24);

    f = cam_k1 * longint'(r2) + cam_k2 * longint'(r4) + cam_k3 * longint'(r6);
    f = clip_s32((longint'(1) << 24) + round_half_up(f, 24));

    xy = clip_s32(round_half_up(x * y, 24));
    qx = clip_u32(r2 + 2 * x2);
    qy = clip_u32(r2 + 2 * y2);

    accx = x * f + 2 * cam_p1 * xy + cam_p2 * longint'(qx);
    accy = y * f + 2 * cam_p2 * xy + cam_p1 * longint'(qy);

    p.x = scale_by_depth(accx, depth);
    p.y = scale_by_depth(accy, depth);
    p.z = dep;
    return p;
  endfunction

  // sender: one pixel word per handshake, random gap after each unless steady_in is set
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_points.push_back(project_pixel(column, row, depth_mm));
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          next_px = pending_pixels.pop_front();
          column   <= next_px.column;
          row      <= next_px.row;
          depth_mm <= next_px.depth;
          in_valid <= 1'b1;
          send_gap = steady_in ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: compare each point word, then stall at random unless steady_out is set
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        $error("point word with nothing expected: x %0d y %0d z %0d",
               point_x, point_y, point_z);
        mismatch_count++;
      end else begin
        want = expected_points.pop_front();
        if (point_x !== want.x) begin
          $error("point_x: expected %0d, got %0d", want.x, point_x);
          mismatch_count++;
        end
        if (point_y !== want.y) begin
          $error("point_y: expected %0d, got %0d", want.y, point_y);
          mismatch_count++;
        end
        if (point_z !== want.z) begin
          $error("point_z: expected %0d, got %0d", want.z, point_z);
          mismatch_count++;
        end
      end
      stall_left = steady_out ? 0 : $urandom_range(0, 3);
      out_stall <= (stall_left != 0);
    end else if (out_valid && stall_left > 0) begin
      stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic queue_pixel(int unsigned c, int unsigned r, int unsigned d);
    pixel_t px;
    px.column = c[9:0];
    px.row    = r[9:0];
    px.depth  = d[15:0];
    pending_pixels.push_back(px);
  endtask

  // random pixels, some with no depth estimate
  task automatic queue_random(int n);
    int unsigned d;
    for (int i = 0; i < n; i++) begin
      d = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 65535);
      queue_pixel($urandom_range(0, 1023), $urandom_range(0, 1023), d);
    end
  endtask

  // hold new pixels until every point is back
  task automatic drain();
    do @(negedge clk);
    while (pending_pixels.size() > 0 || in_valid || expected_points.size() > 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PRINCIPAL_POINT: cam_center = data;
      REG_INV_FOCAL_X:     cam_inv_fx = data[23:0];
      REG_INV_FOCAL_Y:     cam_inv_fy = data[23:0];
      REG_RADIAL_K1:       cam_k1 = longint'(signed'(data[25:0]));
      REG_RADIAL_K2:       cam_k2 = longint'(signed'(data[25:0]));
      REG_RADIAL_K3:       cam_k3 = longint'(signed'(data[25:0]));
      REG_TANGENTIAL_P1:   cam_p1 = longint'(signed'(data[25:0]));
      REG_TANGENTIAL_P2:   cam_p2 = longint'(signed'(data[25:0]));
      default: ;
    endcase
  endtask

  task automatic write_camera(logic [31:0] center, logic [31:0] fx, logic [31:0] fy,
                              logic [31:0] k1, logic [31:0] k2, logic [31:0] k3,
                              logic [31:0] p1, logic [31:0] p2);
    write_reg(REG_PRINCIPAL_POINT, center);
    write_reg(REG_INV_FOCAL_X, fx);
    write_reg(REG_INV_FOCAL_Y, fy);
    write_reg(REG_RADIAL_K1, k1);
    write_reg(REG_RADIAL_K2, k2);
    write_reg(REG_RADIAL_K3, k3);
    write_reg(REG_TANGENTIAL_P1, p1);
    write_reg(REG_TANGENTIAL_P2, p2);
  endtask

  // mostly lens-like coefficients, sometimes any 32-bit word
  function automatic logic [31:0] random_coeff();
    int v;
    if ($urandom_range(0, 3) == 0) return $urandom;
    v = int'($urandom_range(0, 16777216)) - 8388608;
    return v;
  endfunction

  function automatic logic [31:0] random_focal();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $urandom_range(8000, 80000);
  endfunction

  function automatic logic [31:0] random_center();
    int unsigned cx;
    int unsigned cy;
    if ($urandom_range(0, 3) == 0) return $urandom;
    cx = $urandom_range(0, 16383);
    cy = $urandom_range(0, 16383);
    return {cy[15:0], cx[15:0]};
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // default camera: corners, centre, zero and full depth
    queue_pixel(0, 0, 0);
    queue_pixel(0, 0, 65535);
    queue_pixel(1023, 1023, 65535);
    queue_pixel(0, 1023, 1);
    queue_pixel(1023, 0, 65535);
    queue_pixel(424, 240, 1000);
    queue_pixel(1023, 1023, 0);
    queue_pixel(425, 241, 65535);
    queue_random(10);
    drain();

    // largest reciprocals and coefficients, centre at origin: saturation
    steady_in  = 1'b1;
    steady_out = 1'b1;
    write_camera(32'h0000_0000, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h01FF_FFFF,
                 32'h01FF_FFFF, 32'h01FF_FFFF, 32'h01FF_FFFF, 32'h01FF_FFFF);
    queue_pixel(1023, 1023, 65535);
    queue_pixel(0, 0, 65535);
    queue_pixel(1, 0, 1);
    queue_pixel(1023, 0, 32768);
    queue_pixel(0, 1023, 0);
    queue_random(30);
    drain();

    // most negative coefficients, centre at the far corner
    steady_in  = 1'b0;
    steady_out = 1'b1;
    write_camera(32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h0200_0000,
                 32'h0200_0000, 32'h0200_0000, 32'h0200_0000, 32'h0200_0000);
    queue_pixel(0, 0, 65535);
    queue_pixel(1023, 1023, 65535);
    queue_pixel(1023, 0, 1);
    queue_pixel(0, 1023, 65535);
    queue_random(30);
    drain();

    // zero reciprocals: every pixel maps onto the axis
    steady_in  = 1'b1;
    steady_out = 1'b0;
    write_reg(REG_INV_FOCAL_X, 32'h0000_0000);
    write_reg(REG_INV_FOCAL_Y, 32'h0000_0000);
    queue_pixel(1023, 0, 65535);
    queue_pixel(0, 1023, 65535);
    queue_random(8);
    drain();

    // lens-like camera with mild barrel distortion
    steady_in  = 1'b0;
    steady_out = 1'b0;
    write_camera({16'd5760, 16'd10240}, 32'd26214, 32'd26214, 32'h03FF_3334,
                 32'h0001_47AE, 32'h03FF_FEB8, 32'h0000_20C5, 32'h03FF_DF3B);
    queue_random(100);
    drain();

    // assorted cameras and handshake mixes
    for (int ph = 0; ph < 6; ph++) begin
      steady_in  = ($urandom_range(0, 2) == 0);
      steady_out = ($urandom_range(0, 2) == 0);
      write_camera(random_center(), random_focal(), random_focal(), random_coeff(),
                   random_coeff(), random_coeff(), random_coeff(), random_coeff());
      queue_random(65);
      drain();
    end

    repeat (STAGES + 10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
design/dpd_pkg.sv
design/dpd_ctrl.sv
design/dpd_normalize.sv
design/dpd_distort.sv
design/dpd_scale.sv
design/depth_pixel_deprojection.sv
dv/tb.sv
